// ----- rtl/cftw_pkg.sv -----
// Shared types, codes and constants for the CSV field tokenizer.
`default_nettype none

package cftw_pkg;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int WIDTH_BITS_DEF  = 16;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [1:0] CMD_TEXT      = 2'd0;
  localparam logic [1:0] CMD_EOL       = 2'd1;
  localparam logic [1:0] CMD_NEW_TABLE = 2'd2;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_CELL = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_PENDING
  } mode_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value_char;
    logic [7:0]  column_index;
    logic [15:0] cell_width;
    logic [15:0] column_max_width;
    logic        column_overflow;
    logic [6:0]  column_count;
    logic [15:0] row_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

`default_nettype wire

// ----- rtl/csv_field_tokenizer_widths_core.sv -----
// Top level of the CSV field tokenizer with per-column width tracking.
//
// Accepts one beat per cycle while item_stall is low: a text byte, an end of
// line or a new-table command. A beat is held in the input register, then a
// single pass through the quote state machine and the width table writes its
// results into a four-entry result queue, from which they are offered. Most
// beats give at most one result; an end of line that closes an open cell
// gives two, and the result port hands out one beat per cycle while
// result_stall is low, which sets the sustained rate when such lines are very
// short. The column width table lives in a RAM with one flag per entry; reset
// and a new-table command clear all the flags together, so there is no clearing pass.
`default_nettype none

module csv_field_tokenizer_widths_core #(
  parameter int MAX_COLUMNS = cftw_pkg::MAX_COLUMNS_DEF,
  parameter int WIDTH_BITS  = cftw_pkg::WIDTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [15:0]       cfg_wdata,
  input  logic              item_valid,
  output logic              item_stall,
  input  cftw_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output cftw_pkg::result_t result
);

  cftw_pkg::result_pair_t push;
  logic                   space;

  cftw_parser #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .WIDTH_BITS  (WIDTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .space      (space),
    .push       (push)
  );

  cftw_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .space        (space),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- rtl/cftw_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none

module cftw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/cftw_parser.sv -----
// Input register, quote state machine, cell and row tracking, column width table.
`default_nettype none

module cftw_parser #(
  parameter int MAX_COLUMNS = cftw_pkg::MAX_COLUMNS_DEF,
  parameter int WIDTH_BITS  = cftw_pkg::WIDTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [15:0]            cfg_wdata,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  cftw_pkg::item_t        item,
  input  logic                   space,
  output cftw_pkg::result_pair_t push
);

  localparam int AW        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int TBL_DEPTH = 1 << AW;
  localparam int SEEN_W    = $clog2(MAX_COLUMNS + 1);
  localparam logic [8:0] COL_LIMIT = 9'(MAX_COLUMNS);
  localparam logic [WIDTH_BITS-1:0] WIDTH_CAP = '1;

  logic [15:0]           row_limit;
  logic                  pend;
  cftw_pkg::item_t       cur;
  cftw_pkg::mode_t       mode, mode_next;
  logic                  field_open, field_open_next;
  logic [8:0]            column, column_next;
  logic [WIDTH_BITS-1:0] length, length_next;
  logic [SEEN_W-1:0]     seen, seen_next;
  logic [15:0]           rows, rows_next;
  logic [TBL_DEPTH-1:0]  tvalid;
  logic                  byp;
  logic [WIDTH_BITS-1:0] byp_data;

  logic                  fire, limited, ovf, load, tclear, we;
  logic [AW-1:0]         col_idx, raddr;
  logic [7:0]            col_sat;
  logic [WIDTH_BITS-1:0] rdata, tbl, len_inc, cell_max;
  logic [8:0]            col_plus, seen_cand, seen_upd, column_inc;
  logic [15:0]           rows_inc;

  logic                  t_char, t_cell;
  logic [7:0]            t_ch;
  cftw_pkg::mode_t       t_mode;

  cftw_pkg::result_t     char_res, cell_res, row_res;

  assign fire       = pend && space;
  assign item_stall = pend && !space;
  assign load       = item_valid && !item_stall;
  assign limited    = (row_limit != 16'd0) && (rows >= row_limit);
  assign ovf        = column >= COL_LIMIT;
  assign col_idx    = column[AW-1:0];
  assign col_sat    = column[8] ? 8'hFF : column[7:0];
  assign tbl        = byp ? byp_data : (tvalid[col_idx] ? rdata : '0);
  assign len_inc    = (length == WIDTH_CAP) ? length : length + 1'b1;
  assign cell_max   = (length > tbl) ? length : tbl;
  assign col_plus   = column + 9'd1;
  assign seen_cand  = (col_plus > COL_LIMIT) ? COL_LIMIT : col_plus;
  assign seen_upd   = (seen_cand > 9'(seen)) ? seen_cand : 9'(seen);
  assign column_inc = column[8] ? column : col_plus;
  assign rows_inc   = (rows == 16'hFFFF) ? rows : rows + 16'd1;
  assign raddr      = column_next[AW-1:0];

  cftw_ram #(
    .WIDTH (WIDTH_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (col_idx),
    .wdata (cell_max),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    t_char = 1'b0;
    t_cell = 1'b0;
    t_ch   = cur.text_byte;
    t_mode = mode;
    if (!field_open) begin
      if (cur.text_byte == cftw_pkg::CH_QUOTE) begin
        t_mode = cftw_pkg::MODE_QUOTED;
      end else begin
        t_mode = cftw_pkg::MODE_PLAIN;
        t_cell = cur.text_byte == cftw_pkg::CH_COMMA;
        t_char = cur.text_byte != cftw_pkg::CH_COMMA;
      end
    end else begin
      unique case (mode)
        cftw_pkg::MODE_QUOTED: begin
          if (cur.text_byte == cftw_pkg::CH_QUOTE) begin
            t_mode = cftw_pkg::MODE_PENDING;
          end else begin
            t_char = 1'b1;
          end
        end
        cftw_pkg::MODE_PENDING: begin
          if (cur.text_byte == cftw_pkg::CH_QUOTE) begin
            t_mode = cftw_pkg::MODE_QUOTED;
            t_char = 1'b1;
          end else begin
            t_mode = cftw_pkg::MODE_PLAIN;
            t_cell = cur.text_byte == cftw_pkg::CH_COMMA;
            t_char = cur.text_byte != cftw_pkg::CH_COMMA;
          end
        end
        default: begin
          t_cell = cur.text_byte == cftw_pkg::CH_COMMA;
          t_char = cur.text_byte != cftw_pkg::CH_COMMA;
        end
      endcase
    end
  end

  always_comb begin
    char_res            = '0;
    char_res.kind       = cftw_pkg::KIND_CHAR;
    char_res.value_char = t_ch;
    char_res.column_index = col_sat;
    char_res.last       = 1'b1;

    cell_res                  = '0;
    cell_res.kind             = cftw_pkg::KIND_CELL;
    cell_res.column_index     = col_sat;
    cell_res.cell_width       = 16'(length);
    cell_res.column_max_width = ovf ? 16'd0 : 16'(cell_max);
    cell_res.column_overflow  = ovf;

    row_res              = '0;
    row_res.kind         = cftw_pkg::KIND_ROW;
    row_res.column_count = field_open ? 7'(seen_upd) : 7'(seen);
    row_res.row_count    = rows_inc;
    row_res.last         = 1'b1;
  end

  always_comb begin
    mode_next       = mode;
    field_open_next = field_open;
    column_next     = column;
    length_next     = length;
    seen_next       = seen;
    rows_next       = rows;
    tclear          = 1'b0;
    we              = 1'b0;
    push            = '0;
    if (fire) begin
      unique case (cur.cmd)
        cftw_pkg::CMD_NEW_TABLE: begin
          mode_next       = cftw_pkg::MODE_PLAIN;
          field_open_next = 1'b0;
          column_next     = '0;
          length_next     = '0;
          seen_next       = '0;
          rows_next       = '0;
          tclear          = 1'b1;
        end
        cftw_pkg::CMD_TEXT: begin
          if (!limited) begin
            field_open_next = 1'b1;
            mode_next       = t_mode;
            if (t_cell) begin
              mode_next       = cftw_pkg::MODE_PLAIN;
              field_open_next = 1'b0;
              column_next     = column_inc;
              length_next     = '0;
              seen_next       = SEEN_W'(seen_upd);
              we              = !ovf;
              push.count      = 2'd1;
              push.first      = cell_res;
              push.first.last = 1'b1;
            end else if (t_char) begin
              length_next = len_inc;
              push.count  = 2'd1;
              push.first  = char_res;
            end
          end
        end
        cftw_pkg::CMD_EOL: begin
          if (!limited) begin
            mode_next       = cftw_pkg::MODE_PLAIN;
            field_open_next = 1'b0;
            column_next     = '0;
            length_next     = '0;
            rows_next       = rows_inc;
            if (field_open) begin
              seen_next   = SEEN_W'(seen_upd);
              we          = !ovf;
              push.count  = 2'd2;
              push.first  = cell_res;
              push.second = row_res;
            end else begin
              push.count = 2'd1;
              push.first = row_res;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit  <= '0;
      pend       <= 1'b0;
      mode       <= cftw_pkg::MODE_PLAIN;
      field_open <= 1'b0;
      column     <= '0;
      length     <= '0;
      seen       <= '0;
      rows       <= '0;
      tvalid     <= '0;
      byp        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        row_limit <= cfg_wdata;
      end
      if (load) begin
        pend <= 1'b1;
      end else if (fire) begin
        pend <= 1'b0;
      end
      mode       <= mode_next;
      field_open <= field_open_next;
      column     <= column_next;
      length     <= length_next;
      seen       <= seen_next;
      rows       <= rows_next;
      if (tclear) begin
        tvalid <= '0;
      end else if (we) begin
        tvalid[col_idx] <= 1'b1;
      end
      byp <= we && (col_idx == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= item;
    end
    byp_data <= cell_max;
  end

endmodule

`default_nettype wire

// ----- rtl/cftw_out_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one beat per cycle while result_stall is low.
`default_nettype none

module cftw_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  cftw_pkg::result_pair_t push,
  output logic                   space,
  output logic                   result_valid,
  input  logic                   result_stall,
  output cftw_pkg::result_t      result
);

  localparam int DEPTH = cftw_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cftw_pkg::result_t entries [DEPTH];
  logic [PW-1:0]     wp, rp;
  logic [CW-1:0]     count, count_next;
  logic              pop;

  assign pop          = (count != '0) && !result_stall;
  assign result_valid = count != '0;
  assign result       = entries[rp];
  assign space        = count <= CW'(DEPTH - 2);
  assign count_next   = count + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push.count);
      rp    <= rp + PW'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wp + PW'(1)] <= push.second;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= CW'(DEPTH - 2)))
    else $error("push into result queue without room");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.second.last && !push.first.last))
    else $error("last flag misplaced on result pair");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count_next)))
    else $error("result queue count lost track");

endmodule

`default_nettype wire

// ----- sim/tb_csv_field_tokenizer_widths_core.sv -----
// Self-checking testbench for the CSV field tokenizer with column width tracking.
`timescale 1ns / 100ps

module tb_csv_field_tokenizer_widths_core;
  import cftw_pkg::*;

  localparam int          MAXW         = (1 << WIDTH_BITS_DEF) - 1;
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          PHASE_BEATS  = 55;
  localparam int          NUM_PHASES   = 6;
  localparam int          WIDE_ROW     = 260;
  localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;
  localparam result_t     NO_WANT      = '0;

  typedef struct packed {
    item_t   beat;
    logic    fixed;
    result_t want;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  // tokenizer state as seen by the testbench
  logic [15:0] tok_row_limit;
  mode_t       tok_mode;
  logic        tok_open;
  int unsigned tok_col;
  int unsigned tok_len;
  int unsigned tok_seen;
  int unsigned tok_rows;
  logic [15:0] tok_max_width [MAX_COLUMNS_DEF];
  result_t     tok_out [2];
  int          tok_n;

  result_t     expected_tokens [$];
  vector_t     directed_vectors [$];
  result_t     head;

  int send_idle_pct;
  int recv_idle_pct;
  int sent_beats;
  int hold_requests;
  int holds_served;
  int hold_left;
  int quiet_cycles;
  int err_count;

  csv_field_tokenizer_widths_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] ch, logic [7:0] col,
                                          logic [15:0] w, logic [15:0] mw, logic ovf,
                                          logic [6:0] cc, logic [15:0] rc, logic fin);
    result_t r;
    r.kind             = kind;
    r.value_char       = ch;
    r.column_index     = col;
    r.cell_width       = w;
    r.column_max_width = mw;
    r.column_overflow  = ovf;
    r.column_count     = cc;
    r.row_count        = rc;
    r.last             = fin;
    return r;
  endfunction

  function automatic void tok_clear_row();
    tok_mode = MODE_PLAIN;
    tok_open = 1'b0;
    tok_col  = 0;
    tok_len  = 0;
  endfunction

  function automatic void tok_clear_table();
    for (int i = 0; i < MAX_COLUMNS_DEF; i++) tok_max_width[i] = '0;
    tok_seen = 0;
    tok_rows = 0;
    tok_clear_row();
  endfunction

  function automatic void tok_emit_char(logic [7:0] ch);
    int unsigned col;
    col = (tok_col > 255) ? 255 : tok_col;
    if (tok_len < MAXW) tok_len++;
    tok_out[tok_n] = make_result(KIND_CHAR, ch, 8'(col), 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 1'b0);
    tok_n++;
  endfunction

  function automatic void tok_end_cell();
    int unsigned col;
    int unsigned seen;
    logic [15:0] mw;
    logic        ovf;
    col = (tok_col > 255) ? 255 : tok_col;
    mw  = '0;
    ovf = 1'b1;
    if (tok_col < MAX_COLUMNS_DEF) begin
      if (tok_len > tok_max_width[tok_col]) tok_max_width[tok_col] = 16'(tok_len);
      mw  = tok_max_width[tok_col];
      ovf = 1'b0;
    end
    seen = (tok_col + 1 > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : tok_col + 1;
    if (seen > tok_seen) tok_seen = seen;
    tok_out[tok_n] = make_result(KIND_CELL, 8'd0, 8'(col), 16'(tok_len), mw, ovf,
                                 7'd0, 16'd0, 1'b0);
    tok_n++;
    if (tok_col < 256) tok_col++;
    tok_len  = 0;
    tok_open = 1'b0;
    tok_mode = MODE_PLAIN;
  endfunction

  function automatic void tok_plain(logic [7:0] b);
    if (b == CH_COMMA) tok_end_cell();
    else tok_emit_char(b);
  endfunction

  function automatic void tok_step(item_t it);
    result_t r;
    tok_n = 0;
    if (it.cmd == CMD_NEW_TABLE) begin
      tok_clear_table();
    end else if ((it.cmd == CMD_TEXT || it.cmd == CMD_EOL) &&
                 !(tok_row_limit != 0 && tok_rows >= tok_row_limit)) begin
      if (it.cmd == CMD_TEXT) begin
        if (!tok_open) begin
          tok_open = 1'b1;
          tok_mode = MODE_PLAIN;
          if (it.text_byte == CH_QUOTE) tok_mode = MODE_QUOTED;
          else tok_plain(it.text_byte);
        end else if (tok_mode == MODE_QUOTED) begin
          if (it.text_byte == CH_QUOTE) tok_mode = MODE_PENDING;
          else tok_emit_char(it.text_byte);
        end else if (tok_mode == MODE_PENDING) begin
          if (it.text_byte == CH_QUOTE) begin
            tok_mode = MODE_QUOTED;
            tok_emit_char(CH_QUOTE);
          end else begin
            tok_mode = MODE_PLAIN;
            tok_plain(it.text_byte);
          end
        end else begin
          tok_plain(it.text_byte);
        end
      end else begin
        if (tok_open) tok_end_cell();
        if (tok_rows < 16'hFFFF) tok_rows++;
        tok_out[tok_n] = make_result(KIND_ROW, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0,
                                     7'(tok_seen), 16'(tok_rows), 1'b0);
        tok_n++;
        tok_clear_row();
      end
    end
    if (tok_n > 0) begin
      r = tok_out[tok_n - 1];
      r.last = 1'b1;
      tok_out[tok_n - 1] = r;
    end
  endfunction

  task automatic send_beat(logic [1:0] cmd, logic [7:0] b, logic fixed, result_t want);
    item_t it;
    it.cmd       = cmd;
    it.text_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tok_step(it);
    sent_beats++;
    if (fixed) expected_tokens = {expected_tokens, want};
    else for (int i = 0; i < tok_n; i++) expected_tokens = {expected_tokens, tok_out[i]};
  endtask

  task automatic send_text(logic [7:0] b);
    send_beat(CMD_TEXT, b, 1'b0, NO_WANT);
  endtask

  task automatic send_eol();
    send_beat(CMD_EOL, 8'($urandom_range(255)), 1'b0, NO_WANT);
  endtask

  task automatic add_vec(logic [1:0] cmd, logic [7:0] b, logic fixed, result_t want);
    vector_t v;
    v.beat.cmd       = cmd;
    v.beat.text_byte = b;
    v.fixed          = fixed;
    v.want           = want;
    directed_vectors = {directed_vectors, v};
  endtask

  // one random line: mostly well-formed cells, some noise, new-table commands and broken lines
  task automatic gen_line();
    int          r;
    int          ncells;
    int          len;
    int          c;
    int          i;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6))
        send_beat(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, NO_WANT);
    end else if (r < 14) begin
      send_beat(CMD_NEW_TABLE, 8'($urandom_range(255)), 1'b0, NO_WANT);
    end else begin
      ncells = $urandom_range(0, 6);
      for (c = 0; c < ncells; c++) begin
        if (c > 0) send_text(CH_COMMA);
        len = $urandom_range(0, 5);
        if ($urandom_range(1)) begin
          send_text(CH_QUOTE);
          for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            send_text(b);
            if (b == CH_QUOTE) send_text(CH_QUOTE);
          end
          if (!(c == ncells - 1 && $urandom_range(9) == 0)) send_text(CH_QUOTE);
          if ($urandom_range(9) == 0) send_text(8'($urandom_range(255)));
        end else begin
          for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            while (b == CH_COMMA || (i == 0 && b == CH_QUOTE)) b = 8'($urandom_range(255));
            send_text(b);
          end
        end
      end
      if ($urandom_range(9) == 0) send_text(CH_COMMA);
      if ($urandom_range(19) != 0) send_eol();
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen       <= 1'b0;
    tok_row_limit  = v;
  endtask

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      if (err_count < 50)
        $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_tokens.size() == 0) begin
        if (err_count < 50) $display("%0t: unexpected beat %p", $time, result);
        err_count++;
      end else begin
        head = expected_tokens.pop_front();
        check_field("kind", 16'(head.kind), 16'(result.kind));
        check_field("value_char", 16'(head.value_char), 16'(result.value_char));
        check_field("column_index", 16'(head.column_index), 16'(result.column_index));
        check_field("cell_width", head.cell_width, result.cell_width);
        check_field("column_max_width", head.column_max_width, result.column_max_width);
        check_field("column_overflow", 16'(head.column_overflow), 16'(result.column_overflow));
        check_field("column_count", 16'(head.column_count), 16'(result.column_count));
        check_field("row_count", head.row_count, result.row_count);
        check_field("last", 16'(head.last), 16'(result.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_csv_field_tokenizer_widths_core: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] limits [NUM_PHASES];
    vector_t     v;
    int          p;

    send_idle_pct = 26;
    recv_idle_pct = 85;
    tok_row_limit = '0;
    tok_clear_table();

    add_vec(CMD_TEXT, 8'h61, 1'b1,
            make_result(KIND_CHAR, 8'h61, 8'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 1'b1));
    add_vec(CMD_TEXT, 8'hFF, 1'b1,
            make_result(KIND_CHAR, 8'hFF, 8'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 1'b1));
    add_vec(CMD_TEXT, 8'h00, 1'b1,
            make_result(KIND_CHAR, 8'h00, 8'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 1'b1));
    add_vec(CMD_TEXT, CH_COMMA, 1'b1,
            make_result(KIND_CELL, 8'd0, 8'd0, 16'd3, 16'd3, 1'b0, 7'd0, 16'd0, 1'b1));
    add_vec(CMD_TEXT, CH_COMMA, 1'b1,
            make_result(KIND_CELL, 8'd0, 8'd1, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 1'b1));
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_COMMA, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, 8'h79, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_EOL, 8'h00, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, 8'h71, 1'b0, NO_WANT);
    add_vec(CMD_EOL, 8'hFF, 1'b0, NO_WANT);
    add_vec(CMD_UNKNOWN, 8'hAA, 1'b0, NO_WANT);
    add_vec(CMD_EOL, 8'h00, 1'b0, NO_WANT);
    add_vec(CMD_NEW_TABLE, 8'h55, 1'b0, NO_WANT);
    add_vec(CMD_EOL, 8'h00, 1'b1,
            make_result(KIND_ROW, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd1, 1'b1));
    add_vec(CMD_TEXT, CH_COMMA, 1'b1,
            make_result(KIND_CELL, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 1'b1));
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_QUOTE, 1'b0, NO_WANT);
    add_vec(CMD_TEXT, CH_COMMA, 1'b0, NO_WANT);
    add_vec(CMD_EOL, 8'h00, 1'b0, NO_WANT);

    limits[0] = 16'd1;
    limits[1] = 16'hFFFF;
    limits[2] = 16'd3;
    limits[3] = 16'($urandom_range(2, 8));
    limits[4] = 16'd0;
    limits[5] = 16'd2;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_vectors[i]) begin
      v = directed_vectors[i];
      send_beat(v.beat.cmd, v.beat.text_byte, v.fixed, v.want);
    end
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = (p < 2) ? 26 : (p < 4) ? 85 : 0;
      recv_idle_pct = (p < 2) ? 85 : (p < 4) ? 26 : 0;
      write_limit(limits[p]);
      if (p == 4) hold_requests++;
      sent_beats = 0;
      while (sent_beats < PHASE_BEATS) gen_line();
      if (p == 4) begin
        // columns past the table and past the column counter range
        send_eol();
        repeat (WIDE_ROW) send_text(CH_COMMA);
        send_eol();
      end
      drain();
    end

    if (err_count == 0 && expected_tokens.size() == 0)
      $display("tb_csv_field_tokenizer_widths_core: clean");
    else
      $display("tb_csv_field_tokenizer_widths_core: errors");
    $finish;
  end

endmodule
